[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is ignored while reset is high.
`define BCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bcc_pkg.sv]
// Types and constants of the box and circle contact block.
package bcc_pkg;

   localparam int SQ_IN_W   = 63;
   localparam int SQ_OUT_W  = 32;
   localparam int SQ_RES_W  = 64;
   localparam int SQ_STAGES = 32;
   localparam int NUM_W     = 46;
   localparam int DEN_W     = 32;
   localparam int Q_W       = 15;

   localparam logic signed [15:0] NORM_ONE = 16'sd16384;

   typedef struct packed {
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] circle_x;
      logic signed [31:0] circle_y;
      logic        [30:0] circle_radius;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic        [30:0] depth;
      logic signed [31:0] contact_x;
      logic signed [31:0] contact_y;
   } rsp_type;

   // Sideband carried through the square root pipeline.
   typedef struct packed {
      logic        hit;
      logic        in_box;
      logic        vzero;
      logic        sgn_a;
      logic        sgn_b;
      logic [30:0] ua;
      logic [30:0] ub;
      logic [30:0] r;
      logic [31:0] px;
      logic [31:0] py;
   } sq_side_type;

   // Sideband carried through the divider pipeline.
   typedef struct packed {
      logic        hit;
      logic        vzero;
      logic        sgn_a;
      logic        sgn_b;
      logic [30:0] depth;
      logic [31:0] px;
      logic [31:0] py;
   } dv_side_type;

endpackage

[src/bcc_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
module bcc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [bcc_pkg::SQ_IN_W-1:0]   in_val,
   input  bcc_pkg::sq_side_type          in_side,
   output logic                          out_valid,
   output logic [bcc_pkg::SQ_OUT_W-1:0]  out_root,
   output bcc_pkg::sq_side_type          out_side
);
   import bcc_pkg::*;

   logic [SQ_IN_W-1:0]  x_ff    [SQ_STAGES];
   logic [SQ_RES_W-1:0] res_ff  [SQ_STAGES];
   logic                vld_ff  [SQ_STAGES];
   sq_side_type         side_ff [SQ_STAGES];

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
      localparam logic [SQ_RES_W-1:0] BIT = SQ_RES_W'(1) << (2 * (SQ_STAGES - 1 - k));
      logic [SQ_IN_W-1:0]  x_prev;
      logic [SQ_RES_W-1:0] res_prev;
      logic                vld_prev;
      sq_side_type         side_prev;
      logic [SQ_RES_W-1:0] trial;
      logic [SQ_RES_W-1:0] diff;
      logic [SQ_IN_W-1:0]  x_in;
      logic [SQ_RES_W-1:0] res_in;

      if (k == 0) begin : g_first
         assign x_prev    = in_val;
         assign res_prev  = '0;
         assign vld_prev  = in_valid;
         assign side_prev = in_side;
      end else begin : g_next
         assign x_prev    = x_ff[k-1];
         assign res_prev  = res_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         diff  = {1'b0, x_prev} - trial;
         if ({1'b0, x_prev} >= trial) begin
            x_in   = diff[SQ_IN_W-1:0];
            res_in = (res_prev >> 1) + BIT;
         end else begin
            x_in   = x_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            x_ff[k]    <= x_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQ_STAGES-1];
   assign out_root  = res_ff[SQ_STAGES-1][SQ_OUT_W-1:0];
   assign out_side  = side_ff[SQ_STAGES-1];

endmodule

[src/bcc_div.sv]
// Pipelined restoring divider for both normal components, one quotient bit per stage.
module bcc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [bcc_pkg::NUM_W-1:0]   in_num_a,
   input  logic [bcc_pkg::NUM_W-1:0]   in_num_b,
   input  logic [bcc_pkg::DEN_W-1:0]   in_den,
   input  bcc_pkg::dv_side_type        in_side,
   output logic                        out_valid,
   output logic [bcc_pkg::Q_W-1:0]     out_qa,
   output logic [bcc_pkg::Q_W-1:0]     out_qb,
   output bcc_pkg::dv_side_type        out_side
);
   import bcc_pkg::*;

   logic [NUM_W-1:0] ra_ff   [Q_W];
   logic [NUM_W-1:0] rb_ff   [Q_W];
   logic [Q_W-1:0]   qa_ff   [Q_W];
   logic [Q_W-1:0]   qb_ff   [Q_W];
   logic [DEN_W-1:0] den_ff  [Q_W];
   logic             vld_ff  [Q_W];
   dv_side_type      side_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int SH = Q_W - 1 - k;
      logic [NUM_W-1:0] ra_prev, rb_prev;
      logic [Q_W-1:0]   qa_prev, qb_prev;
      logic [DEN_W-1:0] den_prev;
      logic             vld_prev;
      dv_side_type      side_prev;
      logic [NUM_W:0]   dsh;
      logic [NUM_W:0]   da, db;
      logic [NUM_W-1:0] ra_in, rb_in;
      logic [Q_W-1:0]   qa_in, qb_in;

      if (k == 0) begin : g_first
         assign ra_prev   = in_num_a;
         assign rb_prev   = in_num_b;
         assign qa_prev   = '0;
         assign qb_prev   = '0;
         assign den_prev  = in_den;
         assign vld_prev  = in_valid;
         assign side_prev = in_side;
      end else begin : g_next
         assign ra_prev   = ra_ff[k-1];
         assign rb_prev   = rb_ff[k-1];
         assign qa_prev   = qa_ff[k-1];
         assign qb_prev   = qb_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         dsh   = (NUM_W+1)'(den_prev) << SH;
         da    = {1'b0, ra_prev} - dsh;
         db    = {1'b0, rb_prev} - dsh;
         ra_in = ra_prev;
         rb_in = rb_prev;
         qa_in = qa_prev;
         qb_in = qb_prev;
         if ({1'b0, ra_prev} >= dsh) begin
            ra_in     = da[NUM_W-1:0];
            qa_in[SH] = 1'b1;
         end
         if ({1'b0, rb_prev} >= dsh) begin
            rb_in     = db[NUM_W-1:0];
            qb_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            ra_ff[k]   <= ra_in;
            rb_ff[k]   <= rb_in;
            qa_ff[k]   <= qa_in;
            qb_ff[k]   <= qb_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_qa    = qa_ff[Q_W-1];
   assign out_qb    = qb_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

[src/box_circle_contact.sv]
// Box and circle contact test: top level with front stages, normalize stage and output register.
// Fully pipelined: one transaction per cycle. Four front stages clamp, take magnitudes,
// square and compare; a 32-stage square root gives the distance; one stage forms the
// dividends and the depth; a 15-stage divider gives both normal components; the output
// register holds the result. The whole pipeline advances together and holds only while
// a result is waiting and rsp_ready is low.
module box_circle_contact (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bcc_pkg::rsp_type rsp_data
);
   import bcc_pkg::*;

   logic en;

   // stage 1: clamp
   logic               s1_vld_ff;
   logic signed [31:0] s1_px_ff, s1_py_ff, s1_px_in, s1_py_in;
   logic signed [31:0] tx, ty;
   logic [32:0]        s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [33:0]        s1_vx_ff, s1_vy_ff, s1_vx_in, s1_vy_in;
   logic [30:0]        s1_r_ff;

   // stage 2: magnitudes, far test, normal vector
   logic        s2_vld_ff;
   logic        s2_far_ff, s2_far_in, s2_inside_ff, s2_inside_in, s2_vzero_ff, s2_vzero_in;
   logic        s2_sa_ff, s2_sb_ff;
   logic [30:0] s2_ua_ff, s2_ub_ff, s2_ua_in, s2_ub_in, s2_r_ff;
   logic [31:0] s2_px_ff, s2_py_ff;
   logic [32:0] ux, uy;
   logic [33:0] va, vb, ma, mb, mx, sha, shb;
   logic [1:0]  shift;

   // stage 3: squares
   logic        s3_vld_ff;
   logic [61:0] s3_qa_ff, s3_qb_ff, s3_rr_ff;
   logic        s3_far_ff, s3_inside_ff, s3_vzero_ff, s3_sa_ff, s3_sb_ff;
   logic [30:0] s3_ua_ff, s3_ub_ff, s3_r_ff;
   logic [31:0] s3_px_ff, s3_py_ff;

   // stage 4: sum and hit
   logic               s4_vld_ff;
   logic [SQ_IN_W-1:0] s4_sum_ff, s4_sum_in;
   sq_side_type        s4_side_ff, s4_side_in;

   // square root
   logic                sq_vld;
   logic [SQ_OUT_W-1:0] sq_root;
   sq_side_type         sq_side;

   // normalize stage
   logic             p_vld_ff;
   logic [NUM_W-1:0] p_na_ff, p_nb_ff, p_na_in, p_nb_in;
   logic [DEN_W-1:0] p_den_ff, p_den_in;
   dv_side_type      p_side_ff, p_side_in;

   // divider
   logic        dv_vld;
   logic [Q_W-1:0] dv_qa, dv_qb;
   dv_side_type dv_side;

   // output
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic [15:0] mag_a, mag_b;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      tx = (req_data.circle_x < req_data.box_max_x) ? req_data.circle_x : req_data.box_max_x;
      ty = (req_data.circle_y < req_data.box_max_y) ? req_data.circle_y : req_data.box_max_y;
      s1_px_in = (req_data.box_min_x > tx) ? req_data.box_min_x : tx;
      s1_py_in = (req_data.box_min_y > ty) ? req_data.box_min_y : ty;
      s1_dx_in = {req_data.circle_x[31], req_data.circle_x} - {s1_px_in[31], s1_px_in};
      s1_dy_in = {req_data.circle_y[31], req_data.circle_y} - {s1_py_in[31], s1_py_in};
      s1_vx_in = {req_data.circle_x[31], req_data.circle_x, 1'b0}
               - ({{2{req_data.box_min_x[31]}}, req_data.box_min_x}
                + {{2{req_data.box_max_x[31]}}, req_data.box_max_x});
      s1_vy_in = {req_data.circle_y[31], req_data.circle_y, 1'b0}
               - ({{2{req_data.box_min_y[31]}}, req_data.box_min_y}
                + {{2{req_data.box_max_y[31]}}, req_data.box_max_y});
   end

   always_comb begin
      ux = s1_dx_ff[32] ? -s1_dx_ff : s1_dx_ff;
      uy = s1_dy_ff[32] ? -s1_dy_ff : s1_dy_ff;
      s2_far_in    = (ux > {2'b00, s1_r_ff}) || (uy > {2'b00, s1_r_ff});
      s2_inside_in = (s1_dx_ff == '0) && (s1_dy_ff == '0);
      s2_vzero_in  = s2_inside_in && (s1_vx_ff == '0) && (s1_vy_ff == '0);
      va = s2_inside_in ? s1_vx_ff : {s1_dx_ff[32], s1_dx_ff};
      vb = s2_inside_in ? s1_vy_ff : {s1_dy_ff[32], s1_dy_ff};
      ma = va[33] ? -va : va;
      mb = vb[33] ? -vb : vb;
      mx = (ma > mb) ? ma : mb;
      if (mx[33]) begin
         shift = 2'd3;
      end else if (mx[32]) begin
         shift = 2'd2;
      end else if (mx[31]) begin
         shift = 2'd1;
      end else begin
         shift = 2'd0;
      end
      sha = ma >> shift;
      shb = mb >> shift;
      s2_ua_in = sha[30:0];
      s2_ub_in = shb[30:0];
   end

   always_comb begin
      s4_sum_in         = {1'b0, s3_qa_ff} + {1'b0, s3_qb_ff};
      s4_side_in.hit    = !s3_far_ff && (s3_inside_ff || (s4_sum_in <= {1'b0, s3_rr_ff}));
      s4_side_in.in_box = s3_inside_ff;
      s4_side_in.vzero  = s3_vzero_ff;
      s4_side_in.sgn_a  = s3_sa_ff;
      s4_side_in.sgn_b  = s3_sb_ff;
      s4_side_in.ua     = s3_ua_ff;
      s4_side_in.ub     = s3_ub_ff;
      s4_side_in.r      = s3_r_ff;
      s4_side_in.px     = s3_px_ff;
      s4_side_in.py     = s3_py_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         s1_px_ff     <= s1_px_in;
         s1_py_ff     <= s1_py_in;
         s1_dx_ff     <= s1_dx_in;
         s1_dy_ff     <= s1_dy_in;
         s1_vx_ff     <= s1_vx_in;
         s1_vy_ff     <= s1_vy_in;
         s1_r_ff      <= req_data.circle_radius;
         s2_far_ff    <= s2_far_in;
         s2_inside_ff <= s2_inside_in;
         s2_vzero_ff  <= s2_vzero_in;
         s2_sa_ff     <= va[33];
         s2_sb_ff     <= vb[33];
         s2_ua_ff     <= s2_ua_in;
         s2_ub_ff     <= s2_ub_in;
         s2_r_ff      <= s1_r_ff;
         s2_px_ff     <= s1_px_ff;
         s2_py_ff     <= s1_py_ff;
         s3_qa_ff     <= s2_ua_ff * s2_ua_ff;
         s3_qb_ff     <= s2_ub_ff * s2_ub_ff;
         s3_rr_ff     <= s2_r_ff * s2_r_ff;
         s3_far_ff    <= s2_far_ff;
         s3_inside_ff <= s2_inside_ff;
         s3_vzero_ff  <= s2_vzero_ff;
         s3_sa_ff     <= s2_sa_ff;
         s3_sb_ff     <= s2_sb_ff;
         s3_ua_ff     <= s2_ua_ff;
         s3_ub_ff     <= s2_ub_ff;
         s3_r_ff      <= s2_r_ff;
         s3_px_ff     <= s2_px_ff;
         s3_py_ff     <= s2_py_ff;
         s4_sum_ff    <= s4_sum_in;
         s4_side_ff   <= s4_side_in;
      end
   end

   bcc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_val    (s4_sum_ff),
      .in_side   (s4_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      p_na_in = {1'b0, sq_side.ua, 14'b0} + {15'b0, sq_root[SQ_OUT_W-1:1]};
      p_nb_in = {1'b0, sq_side.ub, 14'b0} + {15'b0, sq_root[SQ_OUT_W-1:1]};
      p_den_in = (sq_root == '0) ? DEN_W'(1) : sq_root;
      p_side_in.hit   = sq_side.hit;
      p_side_in.vzero = sq_side.vzero;
      p_side_in.sgn_a = sq_side.sgn_a;
      p_side_in.sgn_b = sq_side.sgn_b;
      p_side_in.depth = sq_side.in_box ? sq_side.r : sq_side.r - sq_root[30:0];
      p_side_in.px    = sq_side.px;
      p_side_in.py    = sq_side.py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= sq_vld;
      end
      if (en) begin
         p_na_ff   <= p_na_in;
         p_nb_ff   <= p_nb_in;
         p_den_ff  <= p_den_in;
         p_side_ff <= p_side_in;
      end
   end

   bcc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_vld_ff),
      .in_num_a  (p_na_ff),
      .in_num_b  (p_nb_ff),
      .in_den    (p_den_ff),
      .in_side   (p_side_ff),
      .out_valid (dv_vld),
      .out_qa    (dv_qa),
      .out_qb    (dv_qb),
      .out_side  (dv_side)
   );

   always_comb begin
      mag_a  = {1'b0, dv_qa};
      mag_b  = {1'b0, dv_qb};
      rsp_in = '0;
      if (dv_side.hit) begin
         rsp_in.hit       = 1'b1;
         rsp_in.depth     = dv_side.depth;
         rsp_in.contact_x = dv_side.px;
         rsp_in.contact_y = dv_side.py;
         if (dv_side.vzero) begin
            rsp_in.normal_x = '0;
            rsp_in.normal_y = -NORM_ONE;
         end else begin
            rsp_in.normal_x = dv_side.sgn_a ? -mag_a : mag_a;
            rsp_in.normal_y = dv_side.sgn_b ? -mag_b : mag_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[src/bcc_checker.sv]
// Port-level checker for the box and circle contact block, with its bind.
`include "assert_macros.svh"

module bcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bcc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bcc_pkg::rsp_type rsp_data
);
   import bcc_pkg::*;

   logic miss_clean, norm_ok, hit_normal;

   assign miss_clean = rsp_data.normal_x == '0 && rsp_data.normal_y == '0
                    && rsp_data.depth == '0 && rsp_data.contact_x == '0
                    && rsp_data.contact_y == '0;
   assign norm_ok    = rsp_data.normal_x <= NORM_ONE && rsp_data.normal_x >= -NORM_ONE
                    && rsp_data.normal_y <= NORM_ONE && rsp_data.normal_y >= -NORM_ONE;
   assign hit_normal = rsp_data.normal_x != '0 || rsp_data.normal_y != '0;

   `BCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result transaction changed while stalled")
   `BCC_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit |-> miss_clean, "miss with nonzero fields")
   `BCC_ASSERT(a_hit_normal, clock, reset, rsp_valid && rsp_data.hit |-> hit_normal, "hit with zero normal")
   `BCC_ASSERT(a_norm_range, clock, reset, rsp_valid |-> norm_ok, "normal out of range")
   `BCC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind box_circle_contact bcc_checker u_bcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[sim/bcc_checker.sv]
// Checker for the box and circle contact block: predicts each result and compares it.
module bcc_monitor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bcc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bcc_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import bcc_pkg::*;

   rsp_type contact_queue[$];

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void unit_normal(input longint a, input longint b,
                                       output logic signed [15:0] na,
                                       output logic signed [15:0] nb);
      logic [63:0] ua, ub, mx, len, qa, qb;
      int s;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      mx = ua > ub ? ua : ub;
      s = 0;
      while (s < 8 && (mx >> s) >= (64'd1 << 31)) s++;
      ua = ua >> s;
      ub = ub >> s;
      len = floor_sqrt(ua * ua + ub * ub);
      if (len == 0) begin
         na = '0;
         nb = -NORM_ONE;
         return;
      end
      qa = (ua * 16384 + len / 2) / len;
      qb = (ub * 16384 + len / 2) / len;
      na = a < 0 ? -qa[15:0] : qa[15:0];
      nb = b < 0 ? -qb[15:0] : qb[15:0];
   endfunction

   function automatic rsp_type predict_contact(input req_type q);
      rsp_type o;
      longint minx, miny, maxx, maxy, cx, cy, px, py, dx, dy, t, vx, vy;
      logic [63:0] r, ux, uy, d2;
      o = '0;
      minx = q.box_min_x; miny = q.box_min_y;
      maxx = q.box_max_x; maxy = q.box_max_y;
      cx = q.circle_x; cy = q.circle_y;
      r = 64'(q.circle_radius);
      t = cx < maxx ? cx : maxx;
      px = minx > t ? minx : t;
      t = cy < maxy ? cy : maxy;
      py = miny > t ? miny : t;
      dx = cx - px; dy = cy - py;
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      if (ux > r || uy > r) return o;
      d2 = ux * ux + uy * uy;
      if (d2 > r * r) return o;
      if (dx == 0 && dy == 0) begin
         vx = 2 * cx - (minx + maxx);
         vy = 2 * cy - (miny + maxy);
         unit_normal(vx, vy, o.normal_x, o.normal_y);
         o.depth = r[30:0];
      end else begin
         unit_normal(dx, dy, o.normal_x, o.normal_y);
         o.depth = 31'(r - floor_sqrt(d2));
      end
      o.hit = 1'b1;
      o.contact_x = px[31:0];
      o.contact_y = py[31:0];
      return o;
   endfunction

   assign pending = contact_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) contact_queue = {contact_queue, predict_contact(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (contact_queue.size() == 0) begin
               $display("%0t unexpected transaction %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = contact_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t mismatch expected %h actual %h", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[sim/testbench.sv]
// Testbench top for the box and circle contact block: stimulus, idling and verdict.
module testbench;
   import bcc_pkg::*;

   logic    clock, reset, req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending, send_idle, recv_idle, idle_cycles;

   box_circle_contact dut (.*);
   bcc_monitor monitor_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL box_circle_contact");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   function automatic logic [31:0] pick_edge();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom;
         default: return $urandom_range(65536 * 40) - 65536 * 20;
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type q;
      logic signed [31:0] cx, cy, hx, hy;
      if ($urandom_range(9) < 2) begin
         q.box_min_x = pick_edge(); q.box_min_y = pick_edge();
         q.box_max_x = pick_edge(); q.box_max_y = pick_edge();
         q.circle_x = pick_edge(); q.circle_y = pick_edge();
         q.circle_radius = $urandom_range(1) ? 31'(pick_edge()) : 31'($urandom);
      end else begin
         // near-contact geometry
         cx = $urandom_range(65536 * 200) - 65536 * 100;
         cy = $urandom_range(65536 * 200) - 65536 * 100;
         hx = $urandom_range(65536 * 20);
         hy = $urandom_range(65536 * 20);
         q.box_min_x = cx - hx; q.box_max_x = cx + hx;
         q.box_min_y = cy - hy; q.box_max_y = cy + hy;
         q.circle_x = cx + $signed($urandom_range(65536 * 60)) - 65536 * 30;
         q.circle_y = cy + $signed($urandom_range(65536 * 60)) - 65536 * 30;
         q.circle_radius = 31'($urandom_range(65536 * 25));
      end
      return q;
   endfunction

   task automatic send_pair(input req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_box(input int x0, y0, x1, y1, cx, cy, r);
      req_type q;
      q.box_min_x = x0; q.box_min_y = y0; q.box_max_x = x1; q.box_max_y = y1;
      q.circle_x = cx; q.circle_y = cy; q.circle_radius = 31'(r);
      send_pair(q);
   endtask

   initial begin
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      send_idle = 0;
      recv_idle = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // coinciding centers, inside, edge touch, far miss, inverted box, wide direction
      send_box(-65536, -65536, 65536, 65536, 0, 0, 65536);
      send_box(-65536, -65536, 65536, 65536, 32768, -16384, 65536);
      send_box(0, 0, 65536, 65536, 131072, 32768, 65536);
      send_box(0, 0, 65536, 65536, 131073, 32768, 65536);
      send_box(0, 0, 65536, 65536, 100000, 100000, 65536);
      send_box(0, 0, 65536, 65536, 900000, 0, 65536);
      send_box(65536, 65536, 0, 0, 32768, 32768, 131072);
      send_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, 0);
      send_box(0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_box(0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_box(-1, -1, -1, -1, -1, -1, 0);
      send_box(32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff,
               32'haaaa_aaaa, 32'h5555_5555, 31'h5555_5555);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1) ? 84 : (ph == 3) ? 34 : 0;
         recv_idle = (ph == 2) ? 84 : (ph == 3) ? 34 : 0;
         for (int i = 0; i < 480; i++) send_pair(random_pair());
         req_valid <= 1'b0;
         while (pending != 0) @(negedge clock);
      end
      repeat (60) @(negedge clock);
      if (fail_count == 0) $display("PASS box_circle_contact");
      else $display("FAIL box_circle_contact");
      $finish;
   end
endmodule
